FILE: hdl/ppsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsu_pkg: shared types and constants of the priority scheduler
// Field widths, slot entry layout, controller states and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package ppsu_pkg;

    localparam int SLOTS_DEF  = 16;

    localparam int ACTION_W   = 1;
    localparam int SLOT_W     = 4;
    localparam int ARRIVAL_W  = 16;
    localparam int BURST_W    = 16;
    localparam int URGENCY_W  = 8;
    localparam int TIME_W     = 32;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef struct packed {
        logic [ARRIVAL_W-1:0] arrive;
        logic [BURST_W-1:0]   service;
        logic [URGENCY_W-1:0] rank;
        logic [BURST_W-1:0]   left;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_EXEC,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_rd;
        logic exec;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

FILE: hdl/ppsu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsu_in_if / ppsu_out_if: scheduler channels
// Valid/ready channels carrying one request beat and one result beat.
// ----------------------------------------------------------------------------
interface ppsu_in_if
    import ppsu_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [ACTION_W-1:0]  action;
    logic [SLOT_W-1:0]    slot;
    logic [ARRIVAL_W-1:0] arrival;
    logic [BURST_W-1:0]   burst;
    logic [URGENCY_W-1:0] urgency;

    modport source (output valid, action, slot, arrival, burst, urgency, input ready);
    modport sink   (input valid, action, slot, arrival, burst, urgency, output ready);
endinterface

interface ppsu_out_if
    import ppsu_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] tick_time;
    logic              idle;
    logic [SLOT_W-1:0] running_slot;
    logic              finished;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              all_done;

    modport source (output valid, tick_time, idle, running_slot, finished, turnaround,
                    waiting, all_done, input ready);
    modport sink   (input valid, tick_time, idle, running_slot, finished, turnaround,
                    waiting, all_done, output ready);
endinterface

FILE: hdl/ppsu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsu_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ppsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/ppsu_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsu_dp: scheduler datapath
// Slot table, pending flags, time counter, best-slot tracking over the scan,
// per-tick update and the result output register.
// ----------------------------------------------------------------------------
module ppsu_dp
    import ppsu_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic [SLOT_W-1:0]    i_slot,
    input  logic [ARRIVAL_W-1:0] i_arrival,
    input  logic [BURST_W-1:0]   i_burst,
    input  logic [URGENCY_W-1:0] i_urgency,
    ppsu_out_if.source           o_out
);

    localparam int IW = $clog2(SLOTS);

    typedef struct packed {
        logic [TIME_W-1:0] tick_time;
        logic              idle;
        logic [SLOT_W-1:0] running_slot;
        logic              finished;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
    } t_res;

    logic [SLOTS-1:0]  r_loaded, r_done;
    logic [TIME_W-1:0] r_now;
    logic [IW-1:0]     r_idx, r_idx_d;
    logic              r_rd_vld;
    logic              r_found;
    logic [IW-1:0]     r_best_idx;
    t_entry            r_best;
    t_res              r_res, r_out;
    t_res              n_res;
    logic              r_out_vld, r_out_all;

    t_entry            rd_entry, wr_entry;
    logic              ram_we;
    logic [IW-1:0]     ram_waddr, load_addr;
    logic              load_ok, eligible, better, fin;
    logic [TIME_W-1:0] done_at, tt, wt;

    assign load_addr = IW'(i_slot);
    assign load_ok   = (32'(i_slot) < 32'(SLOTS));

    // Scan compare on the entry read last cycle
    assign eligible = r_loaded[r_idx_d] && !r_done[r_idx_d]
                      && (TIME_W'(rd_entry.arrive) <= r_now);
    assign better   = !r_found || (rd_entry.rank < r_best.rank);

    // Completion figures for the picked slot
    assign fin     = (r_best.left <= BURST_W'(1));
    assign done_at = r_now + TIME_W'(r_best.left);
    assign tt      = done_at - TIME_W'(r_best.arrive);
    assign wt      = tt - TIME_W'(r_best.service);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_best_idx;
        wr_entry  = r_best;
        if (i_cmd.load) begin
            ram_we           = load_ok;
            ram_waddr        = load_addr;
            wr_entry.arrive  = i_arrival;
            wr_entry.service = i_burst;
            wr_entry.rank    = i_urgency;
            wr_entry.left    = i_burst;
        end else if (i_cmd.exec && r_found && !fin) begin
            ram_we        = 1'b1;
            wr_entry.left = r_best.left - BURST_W'(1);
        end
    end

    always_comb begin
        n_res = r_res;
        if (i_cmd.load) begin
            n_res = '0;
        end else if (i_cmd.exec) begin
            n_res           = '0;
            n_res.tick_time = r_now;
            n_res.idle      = !r_found;
            if (r_found) begin
                n_res.running_slot = SLOT_W'(r_best_idx);
                if (fin) begin
                    n_res.finished   = 1'b1;
                    n_res.turnaround = tt;
                    n_res.waiting    = wt;
                end
            end
        end
    end

    ppsu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_entry),
        .i_raddr (r_idx),
        .o_rdata (rd_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded  <= '0;
            r_done    <= '0;
            r_now     <= '0;
            r_rd_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_rd_vld <= i_cmd.scan_rd;
            if (i_cmd.load && load_ok) begin
                r_loaded[load_addr] <= 1'b1;
                r_done[load_addr]   <= 1'b0;
            end
            if (i_cmd.scan_start) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else if (i_cmd.scan_rd) begin
                r_idx <= r_idx + IW'(1);
            end
            if (r_rd_vld && eligible && better) begin
                r_found <= 1'b1;
            end
            if (i_cmd.exec) begin
                if (r_found && fin) begin
                    r_done[r_best_idx] <= 1'b1;
                    r_now              <= done_at;
                end else begin
                    r_now <= r_now + TIME_W'(1);
                end
            end
            if (i_cmd.push) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd) begin
            r_idx_d <= r_idx;
        end
        if (r_rd_vld && eligible && better) begin
            r_best_idx <= r_idx_d;
            r_best     <= rd_entry;
        end
        r_res <= n_res;
        if (i_cmd.push) begin
            r_out     <= r_res;
            r_out_all <= ~|(r_loaded & ~r_done);
        end
    end

    assign o_sts.scan_last = (r_idx == IW'(SLOTS - 1));
    assign o_sts.out_free  = !r_out_vld || o_out.ready;

    assign o_out.valid        = r_out_vld;
    assign o_out.tick_time    = r_out.tick_time;
    assign o_out.idle         = r_out.idle;
    assign o_out.running_slot = r_out.running_slot;
    assign o_out.finished     = r_out.finished;
    assign o_out.turnaround   = r_out.turnaround;
    assign o_out.waiting      = r_out.waiting;
    assign o_out.all_done     = r_out_all;

endmodule

FILE: hdl/ppsu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsu_ctrl: scheduler controller
// Sequences one request beat: table write and result push for a load, slot
// scan, update and result push for a tick.
// ----------------------------------------------------------------------------
module ppsu_ctrl
    import ppsu_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [ACTION_W-1:0] i_in_action,
    output logic                o_in_ready,
    input  t_sts                i_sts,
    output t_cmd                o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_action == ACT_TICK) begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_PUSH;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_LAST;
                end
            end
            // last entry compares this cycle
            S_LAST: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_PUSH;
            end
            S_PUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/preemptive_priority_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit: preemptive priority scheduler
// Task slot table with per-tick selection of the lowest-rank arrived task.
// ----------------------------------------------------------------------------
// A load beat writes one task slot and then offers its result. A tick beat
// scans the slot table, one entry per cycle through the table RAM read port,
// then does the last compare, the update and the output push in that order;
// the push, for either beat, waits until the output register is free.
// One beat is in work at a time; the next beat is accepted from the cycle in
// which the result is offered, even while that result still sits in the output
// register, and its own result then waits until the earlier one is taken.
// Loads to a slot at or above SLOTS are ignored but still answered.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_unit
    import ppsu_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ppsu_in_if.sink     i_in,
    ppsu_out_if.source  o_out
);

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    assign i_in.ready = in_ready;

    ppsu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_action (i_in.action),
        .o_in_ready  (in_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ppsu_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_slot    (i_in.slot),
        .i_arrival (i_in.arrival),
        .i_burst   (i_in.burst),
        .i_urgency (i_in.urgency),
        .o_out     (o_out)
    );

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && in_ready) |=> !in_ready)
        else $error("request accepted while the previous one is in work");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> sts.out_free)
        else $error("result pushed over an untaken result");

    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.scan_rd && sts.scan_last) |=> (!cmd.scan_rd ##1 cmd.exec))
        else $error("scan did not end in an update");

endmodule
